@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held low.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bus decoder assertion failed");

// Clocked property that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bus decoder assertion failed");

`endif

@@ rtl/core/hmbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbd_pkg
// Types and constants of the handheld memory map bus decoder.
// ----------------------------------------------------------------------------
package hmbd_pkg;

    localparam int unsigned A_AW = 14;   // video + work RAM
    localparam int unsigned B_AW = 9;    // OAM, I/O, high RAM
    localparam int unsigned A_DEPTH = 1 << A_AW;
    localparam int unsigned B_DEPTH = 1 << B_AW;

    localparam logic [1:0] ROUTE_INT  = 2'd0;
    localparam logic [1:0] ROUTE_BOOT = 2'd1;
    localparam logic [1:0] ROUTE_CART = 2'd2;
    localparam logic [1:0] ROUTE_DROP = 2'd3;

    localparam logic [1:0] SRC_FIX = 2'd0;
    localparam logic [1:0] SRC_A   = 2'd1;
    localparam logic [1:0] SRC_B   = 2'd2;
    localparam logic [1:0] SRC_JOY = 2'd3;

    localparam logic [6:0] IO_JOYP = 7'h00;
    localparam logic [6:0] IO_DIV  = 7'h04;
    localparam logic [6:0] IO_TIMA = 7'h05;
    localparam logic [6:0] IO_TMA  = 7'h06;
    localparam logic [6:0] IO_TAC  = 7'h07;
    localparam logic [6:0] IO_LY   = 7'h44;
    localparam logic [6:0] IO_DMA  = 7'h46;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [B_AW-1:0] B_BOOT_OFF = 9'h150;

    localparam logic [7:0] JOYP_WMASK = 8'h30;
    localparam logic [7:0] TAC_OR     = 8'hF8;
    localparam logic [7:0] JOY_ACT_HI = 8'hD0;
    localparam logic [7:0] JOY_DIR_HI = 8'hE0;
    localparam logic [7:0] DIV_INIT   = 8'hAB;

    localparam logic [7:0] IO_INIT [0:127] = '{
        8'hCF,8'h00,8'h7E,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hE1,
        8'h80,8'hBF,8'hF3,8'hFF,8'hBF,8'h00,8'h3F,8'h00,
        8'hFF,8'hBF,8'h7F,8'hFF,8'h9F,8'hFF,8'hBF,8'h00,
        8'hFF,8'h00,8'h00,8'hBF,8'h77,8'hF3,8'hF1,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h91,8'h85,8'h00,8'h00,8'h00,8'h00,8'hFF,8'hFC,
        8'hFF,8'hFF,8'h00,8'h00,8'h00,8'hFF,8'h00,8'hFF,
        8'h00,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'hFF,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'h00,8'h00,
        8'hFF,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    // Bits forced high when an I/O register is written.
    function automatic logic [7:0] io_or_mask(input logic [6:0] idx);
        logic [7:0] m;
        case (idx)
            7'h02:   m = 8'h7E;
            7'h0F:   m = 8'hE0;
            7'h10:   m = 8'h80;
            7'h14:   m = 8'hB8;
            7'h15:   m = 8'hFF;
            7'h19:   m = 8'hB8;
            7'h1A:   m = 8'h7F;
            7'h1C:   m = 8'h9F;
            7'h1E:   m = 8'hB8;
            7'h1F:   m = 8'hFF;
            7'h20:   m = 8'hC0;
            7'h23:   m = 8'hBF;
            7'h26:   m = 8'h70;
            7'h41:   m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic            rd_a;
        logic            we_a;
        logic [A_AW-1:0] idx_a;
        logic            rd_b;
        logic            we_b;
        logic [B_AW-1:0] idx_b;
        logic [7:0]      wdata;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]  src;
        logic [7:0]  fixed;
        logic [7:0]  btn;
        logic [1:0]  route;
        logic [15:0] ext_address;
        logic        ext_write;
        logic [7:0]  ext_data;
        logic        dma_start;
        logic [7:0]  dma_page;
    } t_pend;

endpackage

@@ rtl/core/hmbd_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbd_mem
// Storage of the decoder: one RAM for video and work RAM, one for OAM, I/O
// registers and high RAM, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module hmbd_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmbd_pkg::t_mem_req i_req,
    output logic              o_busy,
    output logic [7:0]        o_a_rdata,
    output logic [7:0]        o_b_rdata
);
    import hmbd_pkg::*;

    logic [7:0]      mem_a [A_DEPTH];
    logic [7:0]      mem_b [B_DEPTH];
    logic            r_busy;
    logic [A_AW-1:0] r_clr_cnt;
    logic [B_AW-1:0] clr_b;
    logic [7:0]      clr_b_val;

    assign o_busy = r_busy;
    assign clr_b  = r_clr_cnt[B_AW-1:0];

    // I/O rows take their power-on value, everything else zero.
    always_comb begin
        if (clr_b[B_AW-1:B_AW-2] == 2'b10) begin
            clr_b_val = IO_INIT[clr_b[6:0]];
        end else begin
            clr_b_val = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (&r_clr_cnt) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem_a[r_clr_cnt] <= 8'h00;
        end else if (i_req.we_a) begin
            mem_a[i_req.idx_a] <= i_req.wdata;
        end
        if (i_req.rd_a) begin
            o_a_rdata <= mem_a[i_req.idx_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem_b[clr_b] <= clr_b_val;
        end else if (i_req.we_b) begin
            mem_b[i_req.idx_b] <= i_req.wdata;
        end
        if (i_req.rd_b) begin
            o_b_rdata <= mem_b[i_req.idx_b];
        end
    end

endmodule

@@ rtl/core/handheld_memory_map_bus_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_memory_map_bus_decoder
// Decodes one CPU access per beat onto the 16-bit memory map.
// Each accepted beat passes the pending and output registers to the master side.
// Throughput: one beat per cycle unless the master side stalls; a RAM read
// issues at accept, its data returns from the single-port RAM next cycle.
// Reset: synchronous, active low; then a clearing pass sweeps the RAMs
// (one entry a cycle) while s_tready stays low.
// ----------------------------------------------------------------------------
module handheld_memory_map_bus_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // bios_present
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // address, write_data, buttons
    input  logic        s_tuser,       // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // read_data, ext_address, ext_write,
                                       // ext_data, dma_start, dma_page,
                                       // select_error, zero pad
    output logic [1:0]  m_tuser        // route
);
    import hmbd_pkg::*;

    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdat;
    logic [7:0]  btn;
    logic        accept;
    logic        advance;
    logic        busy;
    logic [7:0]  a_rdata;
    logic [7:0]  b_rdata;
    t_mem_req    req;
    t_pend       n_pend;
    t_pend       r_pend;
    logic        r_p_valid;

    logic        r_bios;
    logic        r_boot_off;
    logic [7:0]  r_irq;
    logic [7:0]  r_div;
    logic [7:0]  r_tima;
    logic [7:0]  r_tma;
    logic [7:0]  r_tac;
    logic        set_boot_off;
    logic        we_irq;
    logic        clr_div;
    logic        we_tima;
    logic        we_tma;
    logic        we_tac;

    logic        r_o_valid;
    logic [7:0]  r_o_rdata;
    logic        r_o_selerr;
    t_pend       r_o;
    logic [7:0]  n_rdata;
    logic        n_selerr;

    assign wr   = s_tuser;
    assign addr = s_tdata[15:0];
    assign wdat = s_tdata[23:16];
    assign btn  = s_tdata[31:24];

    assign advance  = !r_o_valid || m_tready;
    assign s_tready = !busy && (!r_p_valid || advance);
    assign accept   = s_tvalid && s_tready;

    hmbd_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_busy    (busy),
        .o_a_rdata (a_rdata),
        .o_b_rdata (b_rdata)
    );

    // Decode the beat: issue the RAM access and work out everything else.
    always_comb begin
        logic cart;
        cart         = 1'b0;
        n_pend       = '0;
        n_pend.src   = SRC_FIX;
        n_pend.btn   = btn;
        req          = '0;
        req.idx_a    = {addr[14], addr[12:0]};
        req.idx_b    = addr[B_AW-1:0];
        req.wdata    = wdat;
        set_boot_off = 1'b0;
        we_irq       = 1'b0;
        clr_div      = 1'b0;
        we_tima      = 1'b0;
        we_tma       = 1'b0;
        we_tac       = 1'b0;

        if (wr && addr == ADDR_BOOT_OFF) begin
            set_boot_off = 1'b1;
            req.we_b     = 1'b1;
            req.idx_b    = B_BOOT_OFF;
            req.wdata    = 8'h01;
        end else if (addr <= 16'h00FF) begin
            if (r_boot_off || !r_bios) begin
                cart = 1'b1;
            end else if (wr) begin
                n_pend.route = ROUTE_DROP;
            end else begin
                n_pend.route       = ROUTE_BOOT;
                n_pend.ext_address = addr;
            end
        end else if (addr <= 16'h7FFF) begin
            cart = 1'b1;
        end else if (addr <= 16'h9FFF) begin
            req.we_a = wr;
            req.rd_a = !wr;
            if (!wr) n_pend.src = SRC_A;
        end else if (addr <= 16'hBFFF) begin
            cart = 1'b1;
        end else if (addr <= 16'hFDFF) begin
            // echo region folds onto work RAM through the low 13 bits
            req.we_a = wr;
            req.rd_a = !wr;
            if (!wr) n_pend.src = SRC_A;
        end else if (addr <= 16'hFE9F) begin
            req.we_b = wr;
            req.rd_b = !wr;
            if (!wr) n_pend.src = SRC_B;
        end else if (addr <= 16'hFEFF) begin
            n_pend.route = ROUTE_DROP;
        end else if (addr <= 16'hFF7F) begin
            if (wr) begin
                case (addr[6:0])
                    IO_JOYP: begin
                        req.we_b  = 1'b1;
                        req.wdata = wdat & JOYP_WMASK;
                    end
                    IO_DIV:  clr_div = 1'b1;
                    IO_TIMA: we_tima = 1'b1;
                    IO_TMA:  we_tma  = 1'b1;
                    IO_TAC:  we_tac  = 1'b1;
                    IO_LY:   n_pend.route = ROUTE_DROP;
                    IO_DMA: begin
                        n_pend.dma_start = 1'b1;
                        n_pend.dma_page  = wdat;
                    end
                    default: begin
                        req.we_b  = 1'b1;
                        req.wdata = wdat | io_or_mask(addr[6:0]);
                    end
                endcase
            end else begin
                case (addr[6:0])
                    IO_JOYP: begin
                        req.rd_b   = 1'b1;
                        n_pend.src = SRC_JOY;
                    end
                    IO_DIV:  n_pend.fixed = r_div;
                    IO_TIMA: n_pend.fixed = r_tima;
                    IO_TMA:  n_pend.fixed = r_tma;
                    IO_TAC:  n_pend.fixed = r_tac;
                    default: begin
                        req.rd_b   = 1'b1;
                        n_pend.src = SRC_B;
                    end
                endcase
            end
        end else if (addr <= 16'hFFFE) begin
            req.we_b = wr;
            req.rd_b = !wr;
            if (!wr) n_pend.src = SRC_B;
        end else begin
            we_irq = wr;
            if (!wr) n_pend.fixed = r_irq;
        end

        if (cart) begin
            n_pend.route       = ROUTE_CART;
            n_pend.ext_address = addr;
            n_pend.ext_write   = wr;
            n_pend.ext_data    = wr ? wdat : 8'h00;
        end

        // drop every access when the beat is not taken
        if (!accept) begin
            req.rd_a = 1'b0;
            req.we_a = 1'b0;
            req.rd_b = 1'b0;
            req.we_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bios     <= 1'b0;
            r_boot_off <= 1'b0;
            r_irq      <= 8'h00;
            r_div      <= DIV_INIT;
            r_tima     <= 8'h00;
            r_tma      <= 8'h00;
            r_tac      <= TAC_OR;
        end else begin
            if (i_cfg_we) r_bios <= i_cfg_wdata;
            if (accept) begin
                if (set_boot_off) r_boot_off <= 1'b1;
                if (we_irq)       r_irq  <= wdat;
                if (clr_div)      r_div  <= 8'h00;
                if (we_tima)      r_tima <= wdat;
                if (we_tma)       r_tma  <= wdat;
                if (we_tac)       r_tac  <= wdat | TAC_OR;
            end
        end
    end

    // Pending stage: holds the beat while its RAM read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (advance) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    // Select the read byte; joypad reads combine select bits with buttons.
    always_comb begin
        n_selerr = 1'b0;
        case (r_pend.src)
            SRC_A:   n_rdata = a_rdata;
            SRC_B:   n_rdata = b_rdata;
            SRC_JOY: begin
                if (b_rdata[4]) begin
                    n_rdata = JOY_ACT_HI | {4'h0, r_pend.btn[7:4]};
                end else if (b_rdata[5]) begin
                    n_rdata = JOY_DIR_HI | {4'h0, r_pend.btn[3:0]};
                end else begin
                    n_rdata  = 8'hFF;
                    n_selerr = 1'b1;
                end
            end
            default: n_rdata = r_pend.fixed;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_p_valid) begin
            r_o        <= r_pend;
            r_o_rdata  <= n_rdata;
            r_o_selerr <= n_selerr;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tuser  = r_o.route;
    assign m_tdata  = {5'd0, r_o_selerr, r_o.dma_page, r_o.dma_start, r_o.ext_data,
                       r_o.ext_write, r_o.ext_address, r_o_rdata};

endmodule

@@ rtl/core/hmbd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbd_checker
// Port-level checks on the result stream of the bus decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import hmbd_pkg::*;

    // A stalled result beat holds.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Anything not served internally reads as zero.
    `ASSERT_CLK_RST(a_ext_zero, i_clk, i_rst_n, m_tvalid && m_tuser != ROUTE_INT |-> m_tdata[7:0] == 8'h00)

    // A joypad select error is an internal read of all ones.
    `ASSERT_CLK_RST(a_selerr, i_clk, i_rst_n, m_tvalid && m_tdata[42] |-> m_tuser == ROUTE_INT && m_tdata[7:0] == 8'hFF && !m_tdata[33])

    // A DMA request is an internal write: nothing goes out, nothing reads back.
    `ASSERT_CLK_RST(a_dma, i_clk, i_rst_n, m_tvalid && m_tdata[33] |-> m_tuser == ROUTE_INT && !m_tdata[24] && m_tdata[7:0] == 8'h00)

    // No result survives reset.
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !m_tvalid)

endmodule

bind handheld_memory_map_bus_decoder hmbd_checker u_hmbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the memory map bus decoder. CPU accesses are
// queued, driven on the slave stream with random gaps and predicted at
// accept time against a local copy of every store and register. Results on
// the master stream are checked field by field under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import hmbd_pkg::*;

    // I/O register offsets inside 0xFF00-0xFF7F not named by the package
    localparam logic [6:0] IO_SC   = 7'h02;
    localparam logic [6:0] IO_IF   = 7'h0F;
    localparam logic [6:0] IO_NR10 = 7'h10;
    localparam logic [6:0] IO_NR14 = 7'h14;
    localparam logic [6:0] IO_NR20 = 7'h15;
    localparam logic [6:0] IO_NR24 = 7'h19;
    localparam logic [6:0] IO_NR30 = 7'h1A;
    localparam logic [6:0] IO_NR32 = 7'h1C;
    localparam logic [6:0] IO_NR34 = 7'h1E;
    localparam logic [6:0] IO_NR40 = 7'h1F;
    localparam logic [6:0] IO_NR41 = 7'h20;
    localparam logic [6:0] IO_NR44 = 7'h23;
    localparam logic [6:0] IO_NR52 = 7'h26;
    localparam logic [6:0] IO_STAT = 7'h41;
    localparam logic [6:0] IO_BOOT = 7'h50;

    localparam logic [7:0] IO_POWER_ON [0:127] = '{
        8'hCF,8'h00,8'h7E,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hE1,
        8'h80,8'hBF,8'hF3,8'hFF,8'hBF,8'h00,8'h3F,8'h00,
        8'hFF,8'hBF,8'h7F,8'hFF,8'h9F,8'hFF,8'hBF,8'h00,
        8'hFF,8'h00,8'h00,8'hBF,8'h77,8'hF3,8'hF1,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h91,8'h85,8'h00,8'h00,8'h00,8'h00,8'hFF,8'hFC,
        8'hFF,8'hFF,8'h00,8'h00,8'h00,8'hFF,8'h00,8'hFF,
        8'h00,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'hFF,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'h00,8'h00,
        8'hFF,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    // registers with special write behavior, hit often by the random part
    localparam logic [6:0] HOT_IO [0:21] = '{
        IO_JOYP, IO_SC, IO_DIV, IO_TIMA, IO_TMA, IO_TAC, IO_IF, IO_NR10,
        IO_NR14, IO_NR20, IO_NR24, IO_NR30, IO_NR32, IO_NR34, IO_NR40,
        IO_NR41, IO_NR44, IO_NR52, IO_STAT, IO_LY, IO_DMA, IO_BOOT
    };

    typedef struct {
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  buttons;
    } t_cpu_access;

    typedef struct {
        logic [7:0]  read_data;
        logic [1:0]  route;
        logic [15:0] ext_addr;
        logic        ext_write;
        logic [7:0]  ext_data;
        logic        dma_start;
        logic [7:0]  dma_page;
        logic        select_error;
    } t_bus_result;

    typedef struct {
        logic [15:0] addr;
        t_bus_result res;
    } t_decoded_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // address, write_data, buttons
    logic        s_tuser = 1'b0;    // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // read_data, ext_address, ext_write, ext_data,
                                    // dma_start, dma_page, select_error, pad
    logic [1:0]  m_tuser;           // route

    handheld_memory_map_bus_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // predicted state of the decoder
    logic [7:0] vid_mem  [0:8191];
    logic [7:0] work_mem [0:8191];
    logic [7:0] spr_mem  [0:159];
    logic [7:0] io_mem   [0:127];
    logic [7:0] hi_mem   [0:126];
    logic [7:0] ie_reg, div_reg, tima_reg, tma_reg, tac_reg;
    logic       boot_rom_fitted;

    t_cpu_access     cpu_access_q[$];
    t_decoded_access bus_results_q[$];
    t_cpu_access     beat_in_flight;
    int unsigned     beats_issued = 0;
    int unsigned     beats_taken = 0;
    int unsigned     mismatch_count = 0;
    int unsigned     snd_idle_pct = 9;
    int unsigned     rcv_idle_pct = 64;

    function automatic t_bus_result decode_access(input t_cpu_access acc);
        t_bus_result r;
        logic [15:0] a;
        logic [15:0] w;
        logic [7:0]  d;
        logic [7:0]  rd;
        logic [7:0]  sel;
        logic [6:0]  idx;
        logic        wr;
        logic        cart;
        r = '{default: '0};
        a = acc.addr;
        d = acc.wdata;
        wr = acc.is_write;
        rd = 8'h00;
        cart = 1'b0;
        idx = a[6:0];
        r.route = ROUTE_INT;
        if (wr && a == ADDR_BOOT_OFF) begin
            io_mem[IO_BOOT] = 8'h01;
        end else if (a <= 16'h00FF) begin
            if (io_mem[IO_BOOT] == 8'h01 || !boot_rom_fitted) begin
                cart = 1'b1;
            end else if (wr) begin
                r.route = ROUTE_DROP;
            end else begin
                r.route = ROUTE_BOOT;
                r.ext_addr = a;
            end
        end else if (a <= 16'h7FFF) begin
            cart = 1'b1;
        end else if (a <= 16'h9FFF) begin
            if (wr) vid_mem[a[12:0]] = d; else rd = vid_mem[a[12:0]];
        end else if (a <= 16'hBFFF) begin
            cart = 1'b1;
        end else if (a <= 16'hFDFF) begin
            // echo region folds back onto work RAM
            w = (a >= 16'hE000) ? a - 16'h2000 : a;
            if (wr) work_mem[w[12:0]] = d; else rd = work_mem[w[12:0]];
        end else if (a <= 16'hFE9F) begin
            if (wr) spr_mem[a[7:0]] = d; else rd = spr_mem[a[7:0]];
        end else if (a <= 16'hFEFF) begin
            r.route = ROUTE_DROP;
        end else if (a <= 16'hFF7F) begin
            if (wr) begin
                case (idx)
                    IO_JOYP: io_mem[idx] = d & 8'h30;
                    IO_SC:   io_mem[idx] = d | 8'h7E;
                    IO_DIV:  div_reg = 8'h00;
                    IO_TIMA: tima_reg = d;
                    IO_TMA:  tma_reg = d;
                    IO_TAC:  tac_reg = d | 8'hF8;
                    IO_IF:   io_mem[idx] = d | 8'hE0;
                    IO_NR10: io_mem[idx] = d | 8'h80;
                    IO_NR14: io_mem[idx] = d | 8'hB8;
                    IO_NR20: io_mem[idx] = 8'hFF;
                    IO_NR24: io_mem[idx] = d | 8'hB8;
                    IO_NR30: io_mem[idx] = d | 8'h7F;
                    IO_NR32: io_mem[idx] = d | 8'h9F;
                    IO_NR34: io_mem[idx] = d | 8'hB8;
                    IO_NR40: io_mem[idx] = 8'hFF;
                    IO_NR41: io_mem[idx] = d | 8'hC0;
                    IO_NR44: io_mem[idx] = d | 8'hBF;
                    IO_NR52: io_mem[idx] = d | 8'h70;
                    IO_STAT: io_mem[idx] = d | 8'h80;
                    IO_LY:   r.route = ROUTE_DROP;
                    IO_DMA: begin
                        r.dma_start = 1'b1;
                        r.dma_page = d;
                    end
                    default: io_mem[idx] = d;
                endcase
            end else begin
                case (idx)
                    IO_JOYP: begin
                        sel = io_mem[IO_JOYP];
                        if (sel[4]) begin
                            rd = 8'hD0 | {4'h0, acc.buttons[7:4]};
                        end else if (sel[5]) begin
                            rd = 8'hE0 | {4'h0, acc.buttons[3:0]};
                        end else begin
                            rd = 8'hFF;
                            r.select_error = 1'b1;
                        end
                    end
                    IO_DIV:  rd = div_reg;
                    IO_TIMA: rd = tima_reg;
                    IO_TMA:  rd = tma_reg;
                    IO_TAC:  rd = tac_reg;
                    default: rd = io_mem[idx];
                endcase
            end
        end else if (a <= 16'hFFFE) begin
            if (wr) hi_mem[a[6:0]] = d; else rd = hi_mem[a[6:0]];
        end else begin
            if (wr) ie_reg = d; else rd = ie_reg;
        end
        if (cart) begin
            r.route = ROUTE_CART;
            r.ext_addr = a;
            if (wr) begin
                r.ext_write = 1'b1;
                r.ext_data = d;
            end
        end
        r.read_data = (r.route == ROUTE_INT && !wr) ? rd : 8'h00;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] addr,
                                 input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at %0t: addr %04h %s got %0h want %0h",
                 $realtime, addr, field, got, want);
        mismatch_count++;
    endtask

    // Driver: predict each beat as it is accepted, then load the next one
    always @(posedge i_clk) begin
        t_decoded_access taken;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.addr = beat_in_flight.addr;
                taken.res = decode_access(beat_in_flight);
                bus_results_q = {bus_results_q, taken};
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (cpu_access_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    beat_in_flight = cpu_access_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {beat_in_flight.buttons, beat_in_flight.wdata,
                                beat_in_flight.addr};
                    s_tuser <= beat_in_flight.is_write;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_decoded_access exp_beat;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (bus_results_q.size() == 0) begin
                    note_mismatch("unexpected beat", 16'h0, {14'h0, m_tuser}, 16'h0);
                end else begin
                    exp_beat = bus_results_q.pop_front();
                    if (m_tdata[7:0] !== exp_beat.res.read_data)
                        note_mismatch("read_data", exp_beat.addr, 16'(m_tdata[7:0]),
                                      16'(exp_beat.res.read_data));
                    if (m_tuser !== exp_beat.res.route)
                        note_mismatch("route", exp_beat.addr, 16'(m_tuser),
                                      16'(exp_beat.res.route));
                    if (m_tdata[23:8] !== exp_beat.res.ext_addr)
                        note_mismatch("ext_address", exp_beat.addr, m_tdata[23:8],
                                      exp_beat.res.ext_addr);
                    if (m_tdata[24] !== exp_beat.res.ext_write)
                        note_mismatch("ext_write", exp_beat.addr, 16'(m_tdata[24]),
                                      16'(exp_beat.res.ext_write));
                    if (m_tdata[32:25] !== exp_beat.res.ext_data)
                        note_mismatch("ext_data", exp_beat.addr, 16'(m_tdata[32:25]),
                                      16'(exp_beat.res.ext_data));
                    if (m_tdata[33] !== exp_beat.res.dma_start)
                        note_mismatch("dma_start", exp_beat.addr, 16'(m_tdata[33]),
                                      16'(exp_beat.res.dma_start));
                    if (m_tdata[41:34] !== exp_beat.res.dma_page)
                        note_mismatch("dma_page", exp_beat.addr, 16'(m_tdata[41:34]),
                                      16'(exp_beat.res.dma_page));
                    if (m_tdata[42] !== exp_beat.res.select_error)
                        note_mismatch("select_error", exp_beat.addr, 16'(m_tdata[42]),
                                      16'(exp_beat.res.select_error));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic queue_access(input logic wr, input logic [15:0] addr,
                                input logic [7:0] data, input logic [7:0] btn);
        t_cpu_access acc;
        acc = '{wr, addr, data, btn};
        cpu_access_q = {cpu_access_q, acc};
        beats_issued++;
    endtask

    function automatic logic [15:0] pick_address();
        int unsigned k;
        logic [15:0] off;
        k = $urandom_range(0, 99);
        // a narrow window makes reads land on earlier writes
        off = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 31))
                                          : 16'($urandom_range(0, 16'h1DFF));
        if (k < 6)  return 16'($urandom_range(0, 16'h00FF));
        if (k < 12) return 16'($urandom_range(16'h0100, 16'h7FFF));
        if (k < 22) return 16'h8000 + off + 16'($urandom_range(0, 1) * 16'h200);
        if (k < 26) return 16'($urandom_range(16'hA000, 16'hBFFF));
        if (k < 33) return 16'hC000 + off + 16'($urandom_range(0, 1) * 16'h200);
        if (k < 40) return 16'hE000 + off;
        if (k < 48) return 16'($urandom_range(16'hFE00, 16'hFE9F));
        if (k < 52) return 16'($urandom_range(16'hFEA0, 16'hFEFF));
        if (k < 66) return {9'h1FE, HOT_IO[5'($urandom_range(0, 21))]};
        if (k < 80) return 16'($urandom_range(16'hFF00, 16'hFF7F));
        if (k < 88) return 16'($urandom_range(16'hFF80, 16'hFFFE));
        if (k < 92) return 16'hFFFF;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic queue_random(input int unsigned count, input logic boot_off_ok);
        logic        wr;
        logic [15:0] addr;
        repeat (count) begin
            wr = 1'($urandom_range(0, 1));
            addr = pick_address();
            // hold the boot ROM overlay on until the last phase
            if (wr && addr == ADDR_BOOT_OFF && !boot_off_ok)
                addr = ADDR_BOOT_OFF + 16'h1;
            queue_access(wr, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (beats_taken != beats_issued || bus_results_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_boot_rom(input logic fitted);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fitted;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        boot_rom_fitted = fitted;
    endtask

    initial begin
        for (int i = 0; i < 8192; i++) begin
            vid_mem[13'(i)] = 8'h00;
            work_mem[13'(i)] = 8'h00;
        end
        for (int i = 0; i < 160; i++) spr_mem[8'(i)] = 8'h00;
        for (int i = 0; i < 128; i++) io_mem[7'(i)] = IO_POWER_ON[7'(i)];
        for (int i = 0; i < 127; i++) hi_mem[7'(i)] = 8'h00;
        ie_reg = 8'h00;
        div_reg = DIV_INIT;
        tima_reg = 8'h00;
        tma_reg = 8'h00;
        tac_reg = 8'hF8;
        boot_rom_fitted = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_boot_rom(1'b1);

        // directed: region edges, echo, joypad selects, special I/O writes
        queue_access(1'b0, 16'h0000, 8'h00, 8'h00);
        queue_access(1'b1, 16'h00FF, 8'hFF, 8'hFF);
        queue_access(1'b0, 16'h0100, 8'h00, 8'h00);
        queue_access(1'b1, 16'h7FFF, 8'hA5, 8'h00);
        queue_access(1'b1, 16'h8000, 8'hFF, 8'h00);
        queue_access(1'b0, 16'h8000, 8'h00, 8'h00);
        queue_access(1'b1, 16'h9FFF, 8'h5A, 8'h00);
        queue_access(1'b0, 16'h9FFF, 8'h00, 8'h00);
        queue_access(1'b1, 16'hFDFF, 8'h3C, 8'h00);
        queue_access(1'b0, 16'hDDFF, 8'h00, 8'h00);
        queue_access(1'b1, 16'hC000, 8'h81, 8'h00);
        queue_access(1'b0, 16'hE000, 8'h00, 8'h00);
        queue_access(1'b1, 16'hFE9F, 8'h77, 8'h00);
        queue_access(1'b0, 16'hFE9F, 8'h00, 8'h00);
        queue_access(1'b1, 16'hFEA0, 8'h11, 8'h00);
        queue_access(1'b0, 16'hFEFF, 8'h00, 8'h00);
        queue_access(1'b0, 16'hFF00, 8'h00, 8'hFF);
        queue_access(1'b1, 16'hFF00, 8'hFF, 8'h00);
        queue_access(1'b0, 16'hFF00, 8'h00, 8'h5A);
        queue_access(1'b1, 16'hFF00, 8'h20, 8'h00);
        queue_access(1'b0, 16'hFF00, 8'h00, 8'hA5);
        queue_access(1'b1, 16'hFF04, 8'h55, 8'h00);
        queue_access(1'b0, 16'hFF04, 8'h00, 8'h00);
        queue_access(1'b1, 16'hFF44, 8'h99, 8'h00);
        queue_access(1'b1, 16'hFF46, 8'hC3, 8'h00);
        queue_access(1'b1, 16'hFF15, 8'h00, 8'h00);
        queue_access(1'b1, 16'hFFFF, 8'hFF, 8'h00);
        queue_access(1'b0, 16'hFFFF, 8'h00, 8'h00);
        wait_drained();

        queue_random(450, 1'b0);
        wait_drained();

        set_boot_rom(1'b0);
        snd_idle_pct = 64;
        rcv_idle_pct = 9;
        queue_random(450, 1'b0);
        wait_drained();

        set_boot_rom(1'b1);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(200, 1'b0);
        queue_access(1'b1, ADDR_BOOT_OFF, 8'h00, 8'h00);
        queue_access(1'b0, 16'h0000, 8'h00, 8'h00);
        queue_random(200, 1'b1);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hmbd_pkg.sv
rtl/core/hmbd_mem.sv
rtl/core/handheld_memory_map_bus_decoder.sv
rtl/core/hmbd_checker.sv
tb/testbench.sv
